// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the encrypt core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked every clock, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/aes128_pkg.sv =====
// Shared types, constants and round functions for the AES-128 encrypt core.
`default_nettype none
package aes128_pkg;
  localparam int ROUNDS_DEF    = 10;
  localparam int KEY_WORDS_DEF = 4;
  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } out_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // One round on a 128-bit state (MixColumns skipped when last is set), column 0 in the high word.
  function automatic logic [127:0] enc_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [4][4];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c][r] = sbox(s[127 - 32*((c + r) % 4) - 8*r -: 8]);
    for (int c = 0; c < 4; c++) begin
      a0 = t[c][0]; a1 = t[c][1]; a2 = t[c][2]; a3 = t[c][3];
      if (last) begin
        o[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127 - 32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
    end
    return o ^ rk;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/aes128_block_encrypt_core.sv =====
// Top level of the pipelined AES-128 block encryption core.
//
// Usage:
//   Input channel in_valid/in_ready carries one plaintext block (in_item_t)
//   per transaction; output channel out_valid/out_ready carries the matching
//   ciphertext (out_item_t). Blocks leave in the order they entered.
//   Key: write index 0 (key_high) and index 1 (key_low) on cfg_we/cfg_index/
//   cfg_data. Each write restarts the key expansion (one round key per
//   cycle); issue blocks only after it finishes and the pipe is empty.
//   Pipeline: the initial AddRoundKey register loads at the accepting edge,
//   then one register stage per round, the last stage being the output
//   register. Throughput: one block per cycle unless out_ready stalls the
//   output, set by the ten unrolled round stages.
//   Stall: when out_ready is low and the pipe is full, every stage holds;
//   in_ready drops only then, so a stall loses and repeats nothing.
//   Reset: clears all stage valid bits and the key registers; the round
//   keys are undefined until the first key write expands them.
`default_nettype none
module aes128_block_encrypt_core import aes128_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [63:0] cfg_data
);
`include "assert_macros.svh"

  logic [63:0]               key_high;
  logic [63:0]               key_low;
  logic [ROUNDS:0][127:0]    round_keys;
  logic                      kx_busy;
  logic [127:0]              kx_key;
  logic [ROUNDS:0]           vld;
  logic [ROUNDS:0][127:0]    st;
  logic [ROUNDS:0]           adv;

  // Key registers; the expander sees the value being written.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kx_key = (cfg_index == REG_KEY_HIGH) ? {cfg_data, key_low} : {key_high, cfg_data};

  aes128_key_exp #(.ROUNDS(ROUNDS)) u_kx (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_we),
    .cipher_key (kx_key),
    .round_keys (round_keys),
    .busy       (kx_busy)
  );

  // Stage i advances when it is empty or the next stage takes its content.
  always_comb begin
    adv[ROUNDS] = !vld[ROUNDS] || out_ready;
    for (int i = ROUNDS - 1; i >= 0; i--)
      adv[i] = !vld[i] || adv[i+1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i <= ROUNDS; i++)
        if (adv[i]) vld[i] <= vld[i-1];
    end
  end

  // Stage 0: initial AddRoundKey; stages 1..ROUNDS: one round each.
  always_ff @(posedge clk) begin
    if (adv[0]) st[0] <= in_data ^ round_keys[0];
    for (int i = 1; i <= ROUNDS; i++)
      if (adv[i]) st[i] <= enc_round(st[i-1], round_keys[i], i == ROUNDS);
  end

  assign out_valid = vld[ROUNDS];
  assign out_data  = st[ROUNDS];

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data),
    "stalled result changed")
  `ASSERT_IMPL(a_ready_full, clk, rst, !in_ready, &vld && !out_ready,
    "input stalled with room in pipe")
  `ASSERT_NEXT(a_kx_start, clk, rst, cfg_we, kx_busy, "key expansion did not start")
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_key_exp.sv =====
// Iterative key expansion: one round key per cycle into flop storage.
`default_nettype none
module aes128_key_exp import aes128_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [127:0]             cipher_key,
  output logic      [ROUNDS:0][127:0]   round_keys,
  output logic                          busy
);
  localparam int CW = $clog2(ROUNDS + 1);
  logic [CW-1:0]  step;
  logic [7:0]     rcon;
  logic [127:0]   cur;
  logic [127:0]   nxt;
  logic [31:0]    tw;

  // Previous round key comes from the running register.
  always_comb begin
    tw = sub_word({cur[23:0], cur[31:24]}) ^ {rcon, 24'h0};
    nxt[127:96] = cur[127:96] ^ tw;
    nxt[95:64]  = cur[95:64]  ^ nxt[127:96];
    nxt[63:32]  = cur[63:32]  ^ nxt[95:64];
    nxt[31:0]   = cur[31:0]   ^ nxt[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= CW'(1);
    end else if (busy) begin
      step <= step + CW'(1);
      if (step == CW'(ROUNDS)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur           <= cipher_key;
      rcon          <= 8'h01;
      round_keys[0] <= cipher_key;
    end else if (busy) begin
      cur              <= nxt;
      rcon             <= xtime(rcon);
      round_keys[step] <= nxt;
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the pipelined AES-128 block encryption core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import aes128_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;   // covers key expansion, with margin

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  aes128_block_encrypt_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state: S-box, key registers and expanded schedule.
  logic [7:0]  sub_lut [256];
  logic [63:0] key_hi_q, key_lo_q;
  logic [31:0] sched [44];

  in_item_t  block_q [$];      // plaintext blocks waiting for the driver
  out_item_t cipher_q [$];     // ciphertexts expected from the core
  int        errors = 0;
  int        blocks_in = 0;
  int        blocks_out = 0;
  int        key_writes = 0;
  bit        in_taken = 1'b0;
  int        quiet_cycles = 0;

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // S-box from its definition: GF(2^8) inverse followed by the affine map.
  function automatic logic [7:0] sbox_calc(input logic [7:0] b);
    logic [7:0] inv, s;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gf_mul(inv, b);
    s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    return s;
  endfunction

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {sub_lut[w[31:24]], sub_lut[w[23:16]], sub_lut[w[15:8]], sub_lut[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    sched[0] = key_hi_q[63:32];
    sched[1] = key_hi_q[31:0];
    sched[2] = key_lo_q[63:32];
    sched[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_dbl(rcon);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  function automatic logic [127:0] round_key(input int rnd);
    return {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
  endfunction

  function automatic out_item_t encrypt_block(input in_item_t pt);
    logic [127:0] st, nx;
    logic [7:0]   a [4];
    st = pt ^ round_key(0);
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++) begin
        // SubBytes with ShiftRows: row r comes from column c + r
        for (int r = 0; r < 4; r++) a[r] = sub_lut[st[127 - 32*((c+r)%4) - 8*r -: 8]];
        if (rnd < 10)
          nx[127 - 32*c -: 32] = {
            gf_dbl(a[0]) ^ gf_dbl(a[1]) ^ a[1] ^ a[2] ^ a[3],
            a[0] ^ gf_dbl(a[1]) ^ gf_dbl(a[2]) ^ a[2] ^ a[3],
            a[0] ^ a[1] ^ gf_dbl(a[2]) ^ gf_dbl(a[3]) ^ a[3],
            gf_dbl(a[0]) ^ a[0] ^ a[1] ^ a[2] ^ gf_dbl(a[3])};
        else
          nx[127 - 32*c -: 32] = {a[0], a[1], a[2], a[3]};
      end
      st = nx ^ round_key(rnd);
    end
    return out_item_t'(st);
  endfunction

  // Idle with a chance of 16 in 100, except while blocks 700 to 999 go in, when it never idles.
  function automatic bit take_break();
    if (blocks_in >= 700 && blocks_in < 1000) return 1'b0;
    return $urandom_range(99) < 16;
  endfunction

  // Driver: present the next block at the falling edge; hold until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (block_q.size() > 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_data  <= block_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !take_break();
    end
  end

  // Input monitor: predict each accepted transaction.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      cipher_q.push_back(encrypt_block(in_data));
      void'(block_q.pop_front());
      in_taken = 1'b1;
      blocks_in++;
    end
  end

  // Output monitor: compare against the oldest expected ciphertext.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      blocks_out++;
      if (cipher_q.size() == 0) begin
        $error("unexpected output transaction %h", out_data);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (out_data.out_word0 !== want.out_word0) begin
          $error("out_word0 expected %h actual %h", want.out_word0, out_data.out_word0);
          errors++;
        end
        if (out_data.out_word1 !== want.out_word1) begin
          $error("out_word1 expected %h actual %h", want.out_word1, out_data.out_word1);
          errors++;
        end
        if (out_data.out_word2 !== want.out_word2) begin
          $error("out_word2 expected %h actual %h", want.out_word2, out_data.out_word2);
          errors++;
        end
        if (out_data.out_word3 !== want.out_word3) begin
          $error("out_word3 expected %h actual %h", want.out_word3, out_data.out_word3);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any port.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired: %0d in, %0d out, %0d pending",
               blocks_in, blocks_out, cipher_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Write one key register while idle, then let the expansion finish.
  task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    expand_schedule();
    key_writes++;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Wait until every queued block has gone in and every result has come out.
  task automatic drain();
    while (block_q.size() > 0 || cipher_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t rand_block();
    in_item_t b;
    b = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(15))
      0: b.in_word0 = '0;
      1: b.in_word1 = '1;
      2: b.in_word2 = '0;
      3: b.in_word3 = '1;
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    logic [63:0] kval;
    for (int i = 0; i < 256; i++) sub_lut[i] = sbox_calc(i[7:0]);
    key_hi_q = '0;
    key_lo_q = '0;
    expand_schedule();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: all-zero key, the 00010203.. test key, all-ones key, a partial write, then the 2b7e1516.. key.
    write_key(REG_KEY_HIGH, 64'h0);
    write_key(REG_KEY_LOW, 64'h0);
    block_q.push_back('0);
    block_q.push_back('1);
    block_q.push_back(128'h80000000_00000000_00000000_00000000);
    block_q.push_back(128'h00000000_00000000_00000000_00000001);
    drain();
    write_key(REG_KEY_HIGH, 64'h00010203_04050607);
    write_key(REG_KEY_LOW, 64'h08090a0b_0c0d0e0f);
    block_q.push_back(128'h00112233_44556677_8899aabb_ccddeeff);
    block_q.push_back('0);
    block_q.push_back('1);
    block_q.push_back(128'haaaaaaaa_55555555_aaaaaaaa_55555555);
    block_q.push_back(128'h01234567_89abcdef_fedcba98_76543210);
    drain();
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    block_q.push_back('0);
    block_q.push_back('1);
    block_q.push_back(128'hffffffff_00000000_ffffffff_00000000);
    drain();
    // Partial key write: only the low half changes, high half stays all-ones.
    write_key(REG_KEY_LOW, 64'h0);
    block_q.push_back('0);
    block_q.push_back('1);
    block_q.push_back(128'h3243f6a8_885a308d_313198a2_e0370734);
    drain();
    write_key(REG_KEY_HIGH, 64'h2b7e1516_28aed2a6);
    write_key(REG_KEY_LOW, 64'habf71588_09cf4f3c);
    block_q.push_back(128'h3243f6a8_885a308d_313198a2_e0370734);
    block_q.push_back(128'h6bc1bee2_2e409f96_e93d7e11_7393172a);
    drain();

    // Random phases: new key content per phase, sometimes one half only.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0: write_key(REG_KEY_HIGH, {$urandom, $urandom});
        1: write_key(REG_KEY_LOW, {$urandom, $urandom});
        default: begin
          kval = {$urandom, $urandom};
          write_key(REG_KEY_HIGH, kval);
          write_key(REG_KEY_LOW, {$urandom, $urandom});
        end
      endcase
      for (int n = 0; n < 200; n++) block_q.push_back(rand_block());
      drain();
    end

    $display("ran %0d blocks through %0d key register writes", blocks_in, key_writes);
    $display("keys covered: zero, all-ones, standard vectors, partial and random updates");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
